[rtl/vhfd_pkg.sv]
package vhfd_pkg;

	// Depth of the item queue that sits between the parser and the output stage.
	localparam int QUEUE_DEPTH = 4;

	localparam int SIZE_W   = 23;
	localparam int OPCODE_W = 16;
	localparam int BYTE_W   = 8;

	typedef enum logic [2:0] {
		PH_SIZE0 = 3'd0,
		PH_SIZE1 = 3'd1,
		PH_SIZE2 = 3'd2,
		PH_OPLO  = 3'd3,
		PH_OPHI  = 3'd4,
		PH_DATA  = 3'd5,
		PH_HALT  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	// One classified item as it travels from the parser to the output stage.
	typedef struct packed {
		kind_t                 kind;
		logic [OPCODE_W-1:0]   opcode;
		logic [SIZE_W-1:0]     size;
		logic [BYTE_W-1:0]     data;
		logic                  last;
	} rec_t;

endpackage

[rtl/vhfd_front.sv]
module vhfd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [vhfd_pkg::BYTE_W-1:0]   rx_byte,
	output logic                          rec_valid,
	output vhfd_pkg::rec_t                rec
);

	vhfd_pkg::phase_t phase_q;
	vhfd_pkg::phase_t phase_d;

	logic                          long_q;
	logic [vhfd_pkg::SIZE_W-1:0]   size_q;
	logic [vhfd_pkg::BYTE_W-1:0]   oplo_q;
	logic [vhfd_pkg::SIZE_W-1:0]   rem_q;

	logic [vhfd_pkg::SIZE_W-1:0]   size_shift;
	logic                          size_low;
	logic                          hdr_last;
	logic                          data_last;

	// The first size byte holds at most 7 bits, so shifting in a byte never overflows.
	assign size_shift = {size_q[vhfd_pkg::SIZE_W-9:0], rx_byte};
	assign size_low   = (size_shift < vhfd_pkg::SIZE_W'(2));
	assign hdr_last   = (size_q == vhfd_pkg::SIZE_W'(2));
	assign data_last  = (rem_q == vhfd_pkg::SIZE_W'(1));

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				vhfd_pkg::PH_SIZE0: phase_d = vhfd_pkg::PH_SIZE1;
				vhfd_pkg::PH_SIZE1: begin
					if (long_q) begin
						phase_d = vhfd_pkg::PH_SIZE2;
					end else if (size_low) begin
						phase_d = vhfd_pkg::PH_HALT;
					end else begin
						phase_d = vhfd_pkg::PH_OPLO;
					end
				end
				vhfd_pkg::PH_SIZE2: begin
					phase_d = size_low ? vhfd_pkg::PH_HALT : vhfd_pkg::PH_OPLO;
				end
				vhfd_pkg::PH_OPLO: phase_d = vhfd_pkg::PH_OPHI;
				vhfd_pkg::PH_OPHI: begin
					phase_d = hdr_last ? vhfd_pkg::PH_SIZE0 : vhfd_pkg::PH_DATA;
				end
				vhfd_pkg::PH_DATA: begin
					phase_d = data_last ? vhfd_pkg::PH_SIZE0 : vhfd_pkg::PH_DATA;
				end
				default: phase_d = vhfd_pkg::PH_HALT;
			endcase
		end
	end

	always_comb begin
		rec_valid  = 1'b0;
		rec.kind   = vhfd_pkg::KIND_DATA;
		rec.opcode = {rx_byte, oplo_q};
		rec.size   = size_q;
		rec.data   = rx_byte;
		rec.last   = 1'b0;
		unique case (phase_q)
			vhfd_pkg::PH_SIZE1: begin
				rec_valid = accept & ~long_q & size_low;
				rec.kind  = vhfd_pkg::KIND_ERROR;
				rec.size  = size_shift;
				rec.last  = 1'b1;
			end
			vhfd_pkg::PH_SIZE2: begin
				rec_valid = accept & size_low;
				rec.kind  = vhfd_pkg::KIND_ERROR;
				rec.size  = size_shift;
				rec.last  = 1'b1;
			end
			vhfd_pkg::PH_OPHI: begin
				rec_valid = accept;
				rec.kind  = vhfd_pkg::KIND_HEADER;
				rec.last  = hdr_last;
			end
			vhfd_pkg::PH_DATA: begin
				rec_valid = accept;
				rec.kind  = vhfd_pkg::KIND_DATA;
				rec.last  = data_last;
			end
			default: rec_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= vhfd_pkg::PH_SIZE0;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Field registers are always written before they are read within a frame.
	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (phase_q)
				vhfd_pkg::PH_SIZE0: begin
					long_q <= rx_byte[7];
					size_q <= {{(vhfd_pkg::SIZE_W-7){1'b0}}, rx_byte[6:0]};
				end
				vhfd_pkg::PH_SIZE1: size_q <= size_shift;
				vhfd_pkg::PH_SIZE2: size_q <= size_shift;
				vhfd_pkg::PH_OPLO:  oplo_q <= rx_byte;
				vhfd_pkg::PH_OPHI:  rem_q  <= size_q - vhfd_pkg::SIZE_W'(2);
				vhfd_pkg::PH_DATA:  rem_q  <= rem_q - vhfd_pkg::SIZE_W'(1);
				default: ;
			endcase
		end
	end

endmodule

[rtl/vhfd_fifo.sv]
module vhfd_fifo #(
	parameter int DEPTH = vhfd_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vhfd_pkg::rec_t    push_rec,
	output logic              full,
	input  logic              pop,
	output vhfd_pkg::rec_t    pop_rec,
	output logic              empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	vhfd_pkg::rec_t    entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign pop_rec = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

[rtl/vhfd_back.sv]
module vhfd_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_empty,
	input  vhfd_pkg::rec_t                  in_rec,
	output logic                            in_pop,
	output logic                            empty,
	input  logic                            pop,
	output logic [1:0]                      kind,
	output logic [vhfd_pkg::OPCODE_W-1:0]   frame_opcode,
	output logic [vhfd_pkg::SIZE_W-1:0]     frame_body_size,
	output logic [vhfd_pkg::BYTE_W-1:0]     data_byte,
	output logic                            frame_last
);

	logic             out_valid_q;
	vhfd_pkg::rec_t   out_q;
	vhfd_pkg::rec_t   fmt;

	// Fields that do not belong to an item's kind are shown as zero.
	always_comb begin
		fmt      = in_rec;
		fmt.opcode = (in_rec.kind == vhfd_pkg::KIND_HEADER) ? in_rec.opcode : '0;
		fmt.size   = (in_rec.kind == vhfd_pkg::KIND_DATA) ? '0 : in_rec.size;
		fmt.data   = (in_rec.kind == vhfd_pkg::KIND_DATA) ? in_rec.data : '0;
	end

	assign in_pop = ~in_empty & (~out_valid_q | pop);
	assign empty  = ~out_valid_q;

	assign kind            = out_q.kind;
	assign frame_opcode    = out_q.opcode;
	assign frame_body_size = out_q.size;
	assign data_byte       = out_q.data;
	assign frame_last      = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_pop) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			out_q <= fmt;
		end
	end

endmodule

[rtl/variable_header_frame_deframer.sv]
// Splits a received byte stream into length-prefixed frames, one byte per clock. A frame starts
// with a big-endian body size of two bytes (15 bits), or of three bytes (23 bits) when bit 7 of
// the first byte is set, then a little-endian 16-bit opcode and body size minus two payload
// bytes. One header item (opcode and body size) comes out when the opcode is complete, then one
// item per payload byte; frame_last marks the final item of a frame. A body size below two gives
// an error item, after which every byte is taken and dropped until reset. The parser takes one
// byte in every cycle in which full is low; an item is registered in the queue and then in the
// output register before it reaches the outputs, and full rises only when the QUEUE_DEPTH-entry
// queue and the output register are both occupied because pop is held low.
module variable_header_frame_deframer #(
	parameter int QUEUE_DEPTH = vhfd_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [vhfd_pkg::BYTE_W-1:0]     rx_byte,
	output logic                            empty,
	input  logic                            pop,
	output logic [1:0]                      kind,
	output logic [vhfd_pkg::OPCODE_W-1:0]   frame_opcode,
	output logic [vhfd_pkg::SIZE_W-1:0]     frame_body_size,
	output logic [vhfd_pkg::BYTE_W-1:0]     data_byte,
	output logic                            frame_last
);

	logic             accept;
	logic             rec_valid;
	vhfd_pkg::rec_t   rec;
	logic             q_empty;
	logic             q_pop;
	vhfd_pkg::rec_t   q_rec;

	assign accept = push & ~full;

	vhfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	vhfd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rec_valid),
		.push_rec (rec),
		.full     (full),
		.pop      (q_pop),
		.pop_rec  (q_rec),
		.empty    (q_empty)
	);

	vhfd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_empty        (q_empty),
		.in_rec          (q_rec),
		.in_pop          (q_pop),
		.empty           (empty),
		.pop             (pop),
		.kind            (kind),
		.frame_opcode    (frame_opcode),
		.frame_body_size (frame_body_size),
		.data_byte       (data_byte),
		.frame_last      (frame_last)
	);

endmodule
